/* sv/sra_pkg.sv */
// Shared types and constants for the section address translator.
package sra_pkg;

  localparam int MaxSections = 128;
  localparam int AddrW = (MaxSections > 1) ? $clog2(MaxSections) : 1;
  localparam int CntW = $clog2(MaxSections + 1);
  localparam int EntryW = 96;
  localparam int QDepth = 2;  // power of two, pointers wrap freely
  localparam int QPtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW = $clog2(QDepth + 1);

  localparam logic OpLoad = 1'b0;
  localparam logic OpXlate = 1'b1;

  localparam logic RegImageBase = 1'b0;
  localparam logic RegSectionCount = 1'b1;

  typedef enum logic [1:0] {
    CmdLoad     = 2'd0,
    CmdLoadDrop = 2'd1,
    CmdXlate    = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [AddrW-1:0] index;
    logic [31:0]      start;
    logic [31:0]      length;
    logic [31:0]      offset;
    logic [31:0]      rva;
    logic             use_hint;
  } cmd_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
    logic [31:0] offset;
  } entry_t;

  typedef struct packed {
    logic [QCntW-1:0] count;
    logic             full;
  } fe_status_t;

endpackage

/* sv/sra_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sra_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                             wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                             rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/sra_front.sv */
// Front end: accepts items, classifies them and queues them for the back end.
module sra_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  operation_i,
  input  logic [6:0]            entry_index_i,
  input  logic [31:0]           section_start_i,
  input  logic [31:0]           section_length_i,
  input  logic [31:0]           section_file_offset_i,
  input  logic [31:0]           rva_i,
  input  logic                  use_hint_i,
  output logic                  cmd_valid_o,
  output sra_pkg::cmd_t         cmd_o,
  input  logic                  cmd_pop_i,
  output sra_pkg::fe_status_t   status_o
);

  sra_pkg::cmd_t                q_mem_q [sra_pkg::QDepth];
  logic [sra_pkg::QPtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [sra_pkg::QPtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [sra_pkg::QCntW-1:0]    count_q, count_d;
  logic                         full;
  logic                         push;
  logic                         pop;
  sra_pkg::cmd_t                cmd_new;

  assign full = (count_q == sra_pkg::QCntW'(sra_pkg::QDepth));
  assign push = in_valid_i && !full;
  assign pop  = cmd_pop_i && (count_q != '0);

  // classify: in-range load, dropped load, translate
  always_comb begin
    cmd_new          = '0;
    cmd_new.index    = sra_pkg::AddrW'(entry_index_i);
    cmd_new.start    = section_start_i;
    cmd_new.length   = section_length_i;
    cmd_new.offset   = section_file_offset_i;
    cmd_new.rva      = rva_i;
    cmd_new.use_hint = use_hint_i;
    if (operation_i == sra_pkg::OpLoad) begin
      cmd_new.kind = (32'(entry_index_i) < sra_pkg::MaxSections) ?
                     sra_pkg::CmdLoad : sra_pkg::CmdLoadDrop;
    end else begin
      cmd_new.kind = sra_pkg::CmdXlate;
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + sra_pkg::QPtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + sra_pkg::QPtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + sra_pkg::QCntW'(1);
    end else if (!push && pop) begin
      count_d = count_q - sra_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_new;
    end
  end

  assign in_stall_o      = full;
  assign cmd_valid_o     = (count_q != '0);
  assign cmd_o           = q_mem_q[rd_ptr_q];
  assign status_o.count  = count_q;
  assign status_o.full   = full;

endmodule

/* sv/sra_back.sv */
// Back end: section table, hint check, first-match scan and address sum.
module sra_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cmd_valid_i,
  input  sra_pkg::cmd_t            cmd_i,
  output logic                     cmd_pop_o,
  input  logic [63:0]              image_base_i,
  input  logic [sra_pkg::CntW-1:0] limit_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     found_o,
  output logic [63:0]              address_o,
  output logic [6:0]               hit_index_o,
  output logic                     hint_hit_o
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StHint = 5'b00010,
    StScan = 5'b00100,
    StAdd1 = 5'b01000,
    StAdd2 = 5'b10000
  } state_e;

  state_e                     state_q, state_d;
  logic [sra_pkg::AddrW-1:0]  scan_q, scan_d;
  logic [31:0]                rva_q, rva_d;
  logic                       use_hint_q, use_hint_d;
  logic [sra_pkg::AddrW-1:0]  hint_idx_q, hint_idx_d;
  logic                       hint_vld_q, hint_vld_d;
  logic [31:0]                m_start_q, m_start_d;
  logic [31:0]                m_off_q, m_off_d;
  logic [sra_pkg::AddrW-1:0]  m_idx_q, m_idx_d;
  logic                       m_by_hint_q, m_by_hint_d;
  logic [32:0]                part_q, part_d;

  logic                       out_valid_q;
  logic                       found_q;
  logic [63:0]                address_q;
  logic [6:0]                 hit_index_q;
  logic                       hint_hit_q;

  logic                       ram_we;
  logic [sra_pkg::AddrW-1:0]  ram_raddr;
  logic [sra_pkg::EntryW-1:0] ram_rdata;
  sra_pkg::entry_t            ent;
  sra_pkg::entry_t            ent_new;
  logic                       covers;
  logic                       out_take;
  logic                       slot_free;

  logic                       res_load;
  logic                       res_found;
  logic [63:0]                res_addr;
  logic [6:0]                 res_idx;
  logic                       res_hint;

  assign ent_new.start  = cmd_i.start;
  assign ent_new.length = cmd_i.length;
  assign ent_new.offset = cmd_i.offset;

  sra_ram #(
    .Width (sra_pkg::EntryW),
    .Depth (sra_pkg::MaxSections)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cmd_i.index),
    .wdata_i (ent_new),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ent = sra_pkg::entry_t'(ram_rdata);
  // range end at 33 bits so it never wraps
  assign covers = (rva_q >= ent.start) &&
                  (({1'b0, ent.start} + {1'b0, ent.length}) > {1'b0, rva_q});

  assign out_take  = out_valid_q && !out_stall_i;
  assign slot_free = !out_valid_q || out_take;

  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    rva_d       = rva_q;
    use_hint_d  = use_hint_q;
    hint_idx_d  = hint_idx_q;
    hint_vld_d  = hint_vld_q;
    m_start_d   = m_start_q;
    m_off_d     = m_off_q;
    m_idx_d     = m_idx_q;
    m_by_hint_d = m_by_hint_q;
    part_d      = part_q;
    cmd_pop_o   = 1'b0;
    ram_we      = 1'b0;
    ram_raddr   = scan_q;
    res_load    = 1'b0;
    res_found   = 1'b0;
    res_addr    = '0;
    res_idx     = '0;
    res_hint    = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (cmd_valid_i && slot_free) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.kind)
            sra_pkg::CmdLoad: begin
              ram_we     = 1'b1;
              hint_vld_d = 1'b0;
              res_load   = 1'b1;
            end
            sra_pkg::CmdLoadDrop: begin
              hint_vld_d = 1'b0;
              res_load   = 1'b1;
            end
            sra_pkg::CmdXlate: begin
              rva_d      = cmd_i.rva;
              use_hint_d = cmd_i.use_hint;
              if (cmd_i.use_hint && hint_vld_q) begin
                ram_raddr = hint_idx_q;
                state_d   = StHint;
              end else if (limit_i == '0) begin
                res_load = 1'b1;
              end else begin
                ram_raddr = '0;
                scan_d    = '0;
                state_d   = StScan;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      StHint: begin
        if (covers) begin
          m_start_d   = ent.start;
          m_off_d     = ent.offset;
          m_idx_d     = hint_idx_q;
          m_by_hint_d = 1'b1;
          state_d     = StAdd1;
        end else if (limit_i == '0) begin
          res_load = 1'b1;
          state_d  = StIdle;
        end else begin
          ram_raddr = '0;
          scan_d    = '0;
          state_d   = StScan;
        end
      end
      StScan: begin
        if (covers) begin
          m_start_d   = ent.start;
          m_off_d     = ent.offset;
          m_idx_d     = scan_q;
          m_by_hint_d = 1'b0;
          if (use_hint_q) begin
            hint_idx_d = scan_q;
            hint_vld_d = 1'b1;
          end
          state_d = StAdd1;
        end else if ((sra_pkg::CntW'(scan_q) + sra_pkg::CntW'(1)) < limit_i) begin
          scan_d    = scan_q + sra_pkg::AddrW'(1);
          ram_raddr = scan_q + sra_pkg::AddrW'(1);
        end else begin
          res_load = 1'b1;
          state_d  = StIdle;
        end
      end
      StAdd1: begin
        part_d  = {1'b0, m_off_q} + {1'b0, rva_q - m_start_q};
        state_d = StAdd2;
      end
      StAdd2: begin
        res_load  = 1'b1;
        res_found = 1'b1;
        res_addr  = image_base_i + {31'b0, part_q};
        res_idx   = 7'(m_idx_q);
        res_hint  = m_by_hint_q;
        state_d   = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      hint_idx_q  <= '0;
      hint_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      hint_idx_q <= hint_idx_d;
      hint_vld_q <= hint_vld_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q      <= scan_d;
    rva_q       <= rva_d;
    use_hint_q  <= use_hint_d;
    m_start_q   <= m_start_d;
    m_off_q     <= m_off_d;
    m_idx_q     <= m_idx_d;
    m_by_hint_q <= m_by_hint_d;
    part_q      <= part_d;
    if (res_load) begin
      found_q     <= res_found;
      address_q   <= res_addr;
      hit_index_q <= res_idx;
      hint_hit_q  <= res_hint;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign address_o   = address_q;
  assign hit_index_o = hit_index_q;
  assign hint_hit_o  = hint_hit_q;

endmodule

/* sv/section_rva_translator.sv */
// Top level: section table lookup translating relative addresses to addresses.
// Path: a load goes straight to the result register; a translation checks the remembered
//   entry if asked, else or on its miss scans in order, and a hit sums in StAdd1, StAdd2.
// Throughput: one item at a time in the back end, one table entry per scan cycle, set
//   by the table's single read port; a 2-item queue takes input while the back end works.
// Reset clears control, hint and registers; table entries stay undefined until loaded.
module section_rva_translator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [6:0]  entry_index_i,
  input  logic [31:0] section_start_i,
  input  logic [31:0] section_length_i,
  input  logic [31:0] section_file_offset_i,
  input  logic [31:0] rva_i,
  input  logic        use_hint_i,
  // result item channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic [63:0] address_o,
  output logic [6:0]  hit_index_o,
  output logic        hint_hit_o,
  // register write port
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_wdata_i
);

  logic [63:0]              image_base_q;
  logic [7:0]               section_count_q;
  logic [sra_pkg::CntW-1:0] limit;

  logic                     cmd_valid;
  sra_pkg::cmd_t            cmd;
  logic                     cmd_pop;
  sra_pkg::fe_status_t      fe_status;

  // Config registers; the user must write them only while the block is idle: no logic here checks it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_base_q    <= '0;
      section_count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sra_pkg::RegImageBase:    image_base_q    <= cfg_wdata_i;
        sra_pkg::RegSectionCount: section_count_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Count above the table size searches the whole table.
  assign limit = (32'(section_count_q) > sra_pkg::MaxSections) ?
                 sra_pkg::CntW'(sra_pkg::MaxSections) :
                 sra_pkg::CntW'(section_count_q);

  // Front: take and classify items, buffer them.
  sra_front u_front (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .operation_i           (operation_i),
    .entry_index_i         (entry_index_i),
    .section_start_i       (section_start_i),
    .section_length_i      (section_length_i),
    .section_file_offset_i (section_file_offset_i),
    .rva_i                 (rva_i),
    .use_hint_i            (use_hint_i),
    .cmd_valid_o           (cmd_valid),
    .cmd_o                 (cmd),
    .cmd_pop_i             (cmd_pop),
    .status_o              (fe_status)
  );

  // Back: table writes, hint check, ordered scan, address sum, result reg.
  sra_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .image_base_i (image_base_q),
    .limit_i      (limit),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .found_o      (found_o),
    .address_o    (address_o),
    .hit_index_o  (hit_index_o),
    .hint_hit_o   (hint_hit_o)
  );

  // A hint hit is always a hit.
  a_hint_implies_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hint_hit_o) |-> found_o)
    else $error("hint_hit without found");

  // A miss or load reports zero address and index.
  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (address_o == 64'd0 && hit_index_o == 7'd0))
    else $error("miss result carries nonzero payload");

  // Queue fill never passes its depth.
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fe_status.count) <= sra_pkg::QDepth)
    else $error("front queue overflow");

  // Nothing is popped from an empty queue.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> (fe_status.count != '0))
    else $error("pop from empty queue");

endmodule

/* dv/section_rva_checker.sv */
`timescale 1ns / 1ps
// Channel monitor and result predictor for the section address translator.
module section_rva_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic        operation_i,
  input  logic [6:0]  entry_index_i,
  input  logic [31:0] section_start_i,
  input  logic [31:0] section_length_i,
  input  logic [31:0] section_file_offset_i,
  input  logic [31:0] rva_i,
  input  logic        use_hint_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic        found_o,
  input  logic [63:0] address_o,
  input  logic [6:0]  hit_index_o,
  input  logic        hint_hit_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic        found;
    logic [63:0] address;
    logic [6:0]  hit_index;
    logic        hint_hit;
  } xlat_result_t;

  logic [31:0] tbl_start  [sra_pkg::MaxSections];
  logic [31:0] tbl_length [sra_pkg::MaxSections];
  logic [31:0] tbl_offset [sra_pkg::MaxSections];
  logic [6:0]  hint_idx;
  logic        hint_ok;
  logic [63:0] base_q;
  logic [7:0]  count_q;

  xlat_result_t xlat_results_q[$];
  int unsigned  errors = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  // range end is taken at 33 bits, so a section ending past 2^32 does not wrap
  function automatic logic covers(input int unsigned idx, input logic [31:0] rva);
    logic [32:0] lo;
    logic [32:0] hi;
    if (idx >= sra_pkg::MaxSections) return 1'b0;
    lo = {1'b0, tbl_start[idx]};
    hi = lo + {1'b0, tbl_length[idx]};
    return (lo <= {1'b0, rva}) && (hi > {1'b0, rva});
  endfunction

  task automatic section_lookup(input logic op, input logic [6:0] idx,
                                input logic [31:0] st, input logic [31:0] ln,
                                input logic [31:0] off, input logic [31:0] rva,
                                input logic hint, output xlat_result_t r);
    int unsigned lim;
    int unsigned i;
    logic [31:0] delta;
    r = '0;
    if (op == sra_pkg::OpLoad) begin
      if (idx < sra_pkg::MaxSections) begin
        tbl_start[idx]  = st;
        tbl_length[idx] = ln;
        tbl_offset[idx] = off;
      end
      hint_ok = 1'b0;
    end else begin
      // remembered entry first, regardless of section_count
      if (hint && hint_ok && covers(hint_idx, rva)) begin
        r.found     = 1'b1;
        r.hint_hit  = 1'b1;
        r.hit_index = hint_idx;
      end else begin
        lim = (count_q > sra_pkg::MaxSections) ? sra_pkg::MaxSections : count_q;
        for (i = 0; i < lim && !r.found; i++) begin
          if (covers(i, rva)) begin
            r.found     = 1'b1;
            r.hit_index = i[6:0];
          end
        end
      end
      if (r.found) begin
        delta     = rva - tbl_start[r.hit_index];
        r.address = base_q + {32'd0, tbl_offset[r.hit_index]} + {32'd0, delta};
        if (hint) begin
          hint_idx = r.hit_index;
          hint_ok  = 1'b1;
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    xlat_result_t want;
    if (!rst_ni) begin
      hint_idx = '0;
      hint_ok  = 1'b0;
      base_q   = '0;
      count_q  = '0;
      xlat_results_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == sra_pkg::RegImageBase) base_q = cfg_wdata_i;
        else if (cfg_index_i == sra_pkg::RegSectionCount) count_q = cfg_wdata_i[7:0];
      end
      if (in_valid_i && !in_stall_o) begin
        section_lookup(operation_i, entry_index_i, section_start_i, section_length_i,
                       section_file_offset_i, rva_i, use_hint_i, want);
        xlat_results_q.push_back(want);
      end
      if (out_valid_o && !out_stall_i) begin
        if (xlat_results_q.size() == 0) begin
          report_mismatch("unrequested result", address_o, 64'd0);
        end else begin
          want = xlat_results_q.pop_front();
          if (found_o !== want.found)
            report_mismatch("found", 64'(found_o), 64'(want.found));
          if (address_o !== want.address) report_mismatch("address", address_o, want.address);
          if (hit_index_o !== want.hit_index)
            report_mismatch("hit_index", 64'(hit_index_o), 64'(want.hit_index));
          if (hint_hit_o !== want.hint_hit)
            report_mismatch("hint_hit", 64'(hint_hit_o), 64'(want.hint_hit));
        end
      end
      pending_o <= xlat_results_q.size();
      errors_o  <= errors;
    end
  end

endmodule

/* dv/tb_section_rva_translator.sv */
`timescale 1ns / 1ps
// Stimulus and verdict for the section address translator.
module tb_section_rva_translator;

  localparam int ItemTarget = 600;
  localparam int QuietTail  = 60;    // last items run with no idling at all
  localparam int HoldCycles = 80;    // one long receiver hold-off to back up the input
  localparam int StallLimit = 3000;  // cycles with no item moving on either channel
  localparam int DrainWait  = 140;   // > full miss scan of 128 entries plus hint check

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        operation_i;
  logic [6:0]  entry_index_i;
  logic [31:0] section_start_i;
  logic [31:0] section_length_i;
  logic [31:0] section_file_offset_i;
  logic [31:0] rva_i;
  logic        use_hint_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        found_o;
  logic [63:0] address_o;
  logic [6:0]  hit_index_o;
  logic        hint_hit_o;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [63:0] cfg_wdata_i;

  int unsigned fail_count;
  int unsigned pending_results;

  // stimulus-side copy of what has been loaded, only used to aim addresses at
  // sections and to keep the scan away from entries that were never written
  logic [31:0] sh_start [sra_pkg::MaxSections];
  logic [31:0] sh_len   [sra_pkg::MaxSections];
  bit          sh_loaded[sra_pkg::MaxSections];

  int  items_sent = 0;
  int  lim = 0;          // entries the scan will visit under the current count
  bit  quiet = 1'b0;     // no idling on either side
  bit  calm = 1'b0;      // idle-free stretch for one phase
  bit  hold_req = 1'b0;  // ask the receiver for the long hold-off
  int  idle_cycles = 0;

  always #6 clk_i = ~clk_i;

  section_rva_translator uut (.*);

  section_rva_checker u_checker (
    .errors_o (fail_count),
    .pending_o(pending_results),
    .*
  );

  // ------------------------------------------------------------------
  // Input side: one item per call. Valid goes up with the payload, holds
  // through any stall, and only drops for a gap burst or when the bench settles.
  // ------------------------------------------------------------------
  task automatic send_item(input logic op, input logic [6:0] idx,
                           input logic [31:0] st, input logic [31:0] ln,
                           input logic [31:0] off, input logic [31:0] rva,
                           input logic hint);
    in_valid_i            <= 1'b1;
    operation_i           <= op;
    entry_index_i         <= idx;
    section_start_i       <= st;
    section_length_i      <= ln;
    section_file_offset_i <= off;
    rva_i                 <= rva;
    use_hint_i            <= hint;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    if (items_sent >= ItemTarget - QuietTail) quiet = 1'b1;
    if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // unused payload fields carry random bits so every input bit toggles
  task automatic load_entry(input logic [6:0] idx, input logic [31:0] st,
                            input logic [31:0] ln, input logic [31:0] off);
    sh_start[idx]  = st;
    sh_len[idx]    = ln;
    sh_loaded[idx] = 1'b1;
    send_item(sra_pkg::OpLoad, idx, st, ln, off, $urandom, 1'($urandom_range(0, 1)));
  endtask

  task automatic translate(input logic [31:0] rva, input logic hint);
    send_item(sra_pkg::OpXlate, 7'($urandom_range(0, 127)), $urandom, $urandom, $urandom,
              rva, hint);
  endtask

  // mix of clustered starts (overlaps, first-match order), top-of-space starts
  // (33-bit end), zero and full-size lengths
  task automatic random_entry(output logic [31:0] st, output logic [31:0] ln,
                              output logic [31:0] off);
    case ($urandom_range(0, 3))
      0, 1:    st = $urandom_range(0, 32) << 12;
      2:       st = $urandom;
      default: st = 32'hFFFF_FFFF - $urandom_range(0, 'h3000);
    endcase
    case ($urandom_range(0, 9))
      0:       ln = '0;
      1:       ln = 32'hFFFF_FFFF;
      2, 3:    ln = $urandom;
      4, 5:    ln = $urandom_range(1, 16);
      default: ln = $urandom_range(1, 'h4000);
    endcase
    off = $urandom;
  endtask

  // every item returns one result, so an empty scoreboard means the block is idle
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
  endtask

  task automatic program_regs(input logic [63:0] base, input logic [7:0] count);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= sra_pkg::RegImageBase;
    cfg_wdata_i <= base;
    @(posedge clk_i);
    cfg_index_i <= sra_pkg::RegSectionCount;
    cfg_wdata_i <= {56'd0, count};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    lim = (count > sra_pkg::MaxSections) ? sra_pkg::MaxSections : count;
  endtask

  // ------------------------------------------------------------------
  // Output side: random stall bursts separated by open runs; one long
  // hold-off on request so the internal queue fills and input stalls.
  // ------------------------------------------------------------------
  initial begin : receiver
    logic level;
    int   n;
    out_stall_i <= 1'b0;
    forever begin
      if (hold_req) begin
        level    = 1'b1;
        n        = HoldCycles;
        hold_req = 1'b0;
      end else if (quiet || calm || out_stall_i || $urandom_range(0, 3) != 0) begin
        level = 1'b0;
        n     = $urandom_range(1, 12);
      end else begin
        level = 1'b1;
        n     = $urandom_range(1, 17);
      end
      out_stall_i <= level;
      repeat (n) @(posedge clk_i);
    end
  end

  // watchdog: nothing moving for too long means a hang
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] st, ln, off, rva, last_rva;
    logic [63:0] base;
    logic [7:0]  count;
    logic        hint;
    int          phase, burst, sel, k, i;

    rst_ni                <= 1'b0;
    in_valid_i            <= 1'b0;
    operation_i           <= sra_pkg::OpLoad;
    entry_index_i         <= '0;
    section_start_i       <= '0;
    section_length_i      <= '0;
    section_file_offset_i <= '0;
    rva_i                 <= '0;
    use_hint_i            <= 1'b0;
    cfg_we_i              <= 1'b0;
    cfg_index_i           <= sra_pkg::RegImageBase;
    cfg_wdata_i           <= '0;
    last_rva = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part ---
    // reset registers: nothing to search, so a plain miss
    translate(32'h0000_1000, 1'b0);

    // all-ones base so translated addresses wrap past 2^64
    program_regs(64'hFFFF_FFFF_FFFF_FFFF, 8'd4);
    load_entry(7'd0, 32'h0000_1000, 32'h0000_0100, 32'h0000_0400);
    load_entry(7'd1, 32'h0000_2000, 32'h0000_0000, 32'h0000_0123);  // zero length
    load_entry(7'd2, 32'hFFFF_FF00, 32'h0000_0200, 32'hFFFF_FFFF);  // end above 2^32
    load_entry(7'd3, 32'h0000_1080, 32'h0000_1000, 32'h0000_0000);  // overlaps entry 0
    load_entry(7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    translate(32'h0000_1000, 1'b1);  // scan hit on entry 0, remembered
    translate(32'h0000_10FF, 1'b1);  // remembered entry hit, last byte
    translate(32'h0000_1100, 1'b1);  // just past entry 0: scan finds entry 3
    translate(32'h0000_1090, 1'b1);  // remembered entry 3 wins over lower entry 0
    translate(32'h0000_1090, 1'b0);  // no hint: first match is entry 0, hint untouched
    translate(32'h0000_2000, 1'b0);  // skips zero-length entry 1
    translate(32'h0000_2080, 1'b1);  // exact end of entry 3: miss, hint kept
    translate(32'hFFFF_FFFF, 1'b1);  // top address inside entry 2, no 32-bit wrap
    translate(32'h0000_0000, 1'b1);  // miss with hint set
    translate(32'hFFFF_FF00, 1'b1);  // remembered entry 2 still live
    load_entry(7'd3, 32'h0000_1080, 32'h0000_1000, 32'h0000_0000);  // drops hint
    translate(32'hFFFF_FF80, 1'b1);  // hint gone: found by scan
    translate(32'h0000_1500, 1'b1);  // remember entry 3

    // hint sits above the new count and still answers; the scan does not
    program_regs(64'd0, 8'd2);
    translate(32'h0000_1500, 1'b1);
    translate(32'h0000_1500, 1'b0);
    translate(32'hFFFF_FFFF, 1'b0);
    last_rva = 32'h0000_1500;

    // --- random part, in phases with fresh register settings ---
    phase = 0;
    while (items_sent < ItemTarget) begin
      case (phase)
        0:       count = 8'd3;
        1:       count = 8'd255;  // above table size: clamps to all entries
        2:       count = 8'd128;
        default: begin
          case ($urandom_range(0, 9))
            0:       count = 8'd0;
            1:       count = 8'd1;
            2, 3, 4: count = 8'($urandom_range(2, 8));
            5:       count = 8'($urandom_range(9, 40));
            6:       count = 8'd127;
            7:       count = 8'd128;
            8:       count = 8'($urandom_range(129, 254));
            default: count = 8'd255;
          endcase
        end
      endcase
      case ($urandom_range(0, 4))
        0:       base = '0;
        1:       base = '1;
        2:       base = {32'hFFFF_FFFF, 32'($urandom)};
        default: base = {32'($urandom), 32'($urandom)};
      endcase
      program_regs(base, count);

      // the scan must only ever touch loaded entries
      for (i = 0; i < lim; i++) begin
        if (!sh_loaded[i]) begin
          random_entry(st, ln, off);
          load_entry(i[6:0], st, ln, off);
        end
      end

      calm = (phase != 1) && ($urandom_range(0, 3) == 0);
      if (phase == 1) hold_req = 1'b1;

      burst = $urandom_range(20, 60);
      repeat (burst) begin
        sel = $urandom_range(0, 99);
        if (sel < 15) begin
          k = ($urandom_range(0, 1) && lim > 0) ? $urandom_range(0, lim - 1)
                                               : $urandom_range(0, sra_pkg::MaxSections - 1);
          random_entry(st, ln, off);
          load_entry(k[6:0], st, ln, off);
        end else begin
          hint = ($urandom_range(0, 9) < 7);
          k = (lim > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, lim - 1)
                                                     : $urandom_range(0, sra_pkg::MaxSections - 1);
          if (!sh_loaded[k] || sel >= 85) begin
            rva = $urandom;
          end else if (sel < 60) begin
            rva = sh_start[k] + ((sh_len[k] == 0) ? 32'd0 : 32'($urandom) % sh_len[k]);
          end else if (sel < 72) begin
            // section edges: first byte, one before, one past the end
            case ($urandom_range(0, 2))
              0:       rva = sh_start[k];
              1:       rva = sh_start[k] - 32'd1;
              default: rva = sh_start[k] + sh_len[k];
            endcase
          end else begin
            rva = last_rva + $urandom_range(0, 63);  // locality for hint hits
          end
          translate(rva, hint);
          last_rva = rva;
        end
      end
      phase++;
    end

    settle();
    repeat (DrainWait) @(posedge clk_i);
    if (fail_count == 0 && pending_results == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
